// ===== hdl/dss_pkg.sv =====
// dss_pkg: shared types, constants and helper functions for the decode stage
// with register scoreboard. No dependencies; used by every other file.
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

  // storage sizing
  localparam int NUM_REGS    = 33;
  localparam int DATA_WIDTH  = 32;
  localparam int COUNT_WIDTH = 3;
  localparam int GPR_COUNT   = NUM_REGS - 1;
  localparam int IDX_W       = (GPR_COUNT > 1) ? $clog2(GPR_COUNT) : 1;

  // writeback index of the link reservation register
  localparam logic [5:0] LINK_IDX = 6'(NUM_REGS - 1);

  // item kinds
  localparam logic OP_DECODE    = 1'b0;
  localparam logic OP_WRITEBACK = 1'b1;

  // opcodes
  localparam logic [9:0] OPC_BUBBLE = 10'd1;
  localparam logic [9:0] OPC_CSW    = 10'd3;
  localparam logic [9:0] OPC_LW     = 10'd5;
  localparam logic [9:0] OPC_ADDI   = 10'd19;
  localparam logic [9:0] OPC_SW     = 10'd37;
  localparam logic [9:0] OPC_LR     = 10'd51;
  localparam logic [9:0] OPC_SC     = 10'd52;
  localparam logic [9:0] OPC_DIV    = 10'd56;
  localparam logic [9:0] OPC_ADD    = 10'd71;
  localparam logic [9:0] OPC_MUL    = 10'd72;
  localparam logic [9:0] OPC_SUB    = 10'd83;
  localparam logic [9:0] OPC_BEQ    = 10'd99;
  localparam logic [9:0] OPC_BNE    = 10'd100;
  localparam logic [9:0] OPC_JALR   = 10'd103;
  localparam logic [9:0] OPC_JAL    = 10'd111;
  localparam logic [9:0] OPC_NOP    = 10'd999;

  typedef logic [IDX_W-1:0]       gpr_idx_t;
  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [DATA_WIDTH-1:0]  reg_t;

  localparam cnt_t CNT_MAX = {COUNT_WIDTH{1'b1}};

  // input item
  typedef struct packed {
    logic               op;
    logic [9:0]         opcode;
    logic [4:0]         field_first;
    logic [4:0]         field_second;
    logic signed [31:0] field_third;
    logic               stall_in;
    logic [31:0]        pc_value;
    logic [5:0]         wb_index;
    logic signed [31:0] wb_value;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [9:0]         out_opcode;
    logic [4:0]         out_first;
    logic [4:0]         out_second;
    logic signed [31:0] out_third;
    logic               stage_status;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic signed [31:0] immediate_out;
    logic [31:0]        branch_target;
    logic signed [31:0] link_value;
  } out_item_t;

  // scoreboard read addresses: two source ports and the reservation port
  typedef struct packed {
    gpr_idx_t a;
    gpr_idx_t b;
    gpr_idx_t r;
  } rd_addr_t;

  // scoreboard updates made when an item leaves the input register
  typedef struct packed {
    logic     gpr_we;
    gpr_idx_t gpr_idx;
    reg_t     gpr_data;
    logic     link_we;
    reg_t     link_data;
    logic     cnt_we;
    gpr_idx_t cnt_idx;
    cnt_t     cnt_data;
    logic     link_cnt_we;
    cnt_t     link_cnt_data;
  } sb_wr_t;

  // resolved scoreboard view of the item in the input register
  typedef struct packed {
    logic [31:0] val_a;
    logic [31:0] val_b;
    logic [31:0] link_val;
    logic        busy_a;
    logic        busy_b;
    logic        link_busy;
    cnt_t        cnt_r;
    cnt_t        link_cnt;
  } sb_rsp_t;

  // register indexes an item reads and reserves
  function automatic rd_addr_t src_addrs(input in_item_t it);
    rd_addr_t ad;
    logic     f1_pair;
    logic     f3_src;
    f1_pair = (it.opcode == OPC_SW) || (it.opcode == OPC_BEQ) ||
              (it.opcode == OPC_BNE) || (it.opcode == OPC_SC);
    f3_src  = (it.opcode == OPC_ADD) || (it.opcode == OPC_SUB) ||
              (it.opcode == OPC_MUL) || (it.opcode == OPC_DIV);
    ad.a = f1_pair ? IDX_W'(it.field_first) : IDX_W'(it.field_second);
    ad.b = f3_src ? it.field_third[IDX_W-1:0] : IDX_W'(it.field_second);
    if (it.op == OP_WRITEBACK) begin
      ad.r = it.wb_index[IDX_W-1:0];
    end else if (it.opcode == OPC_SC) begin
      ad.r = IDX_W'(it.field_second);
    end else begin
      ad.r = IDX_W'(it.field_first);
    end
    return ad;
  endfunction

  // saturating pending-count steps
  function automatic cnt_t cnt_inc(input cnt_t c);
    return (c == CNT_MAX) ? c : c + cnt_t'(1);
  endfunction

  function automatic cnt_t cnt_dec(input cnt_t c);
    return (c == '0) ? c : c - cnt_t'(1);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dss_score.sv =====
// dss_score: register file and pending-write counts with registered reads,
// valid bits for reset state and forwarding of the last update.
// Depends on dss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dss_score (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire dss_pkg::rd_addr_t rd_addr,
  input  wire dss_pkg::sb_wr_t   wr,
  output dss_pkg::sb_rsp_t       rsp
);
  import dss_pkg::*;

  // general registers and two copies of the counts (three read ports total)
  reg_t gpr_mem_r    [GPR_COUNT];
  cnt_t cnt_ab_mem_r [GPR_COUNT];
  cnt_t cnt_rs_mem_r [GPR_COUNT];

  logic [GPR_COUNT-1:0] gpr_vld_r;
  logic [GPR_COUNT-1:0] cnt_vld_r;

  // link reservation register lives in flops
  reg_t link_r;
  cnt_t link_cnt_r;

  // registered read data
  rd_addr_t addr_q_r;
  reg_t     gpr_a_q_r, gpr_b_q_r;
  cnt_t     cnt_a_q_r, cnt_b_q_r, cnt_r_q_r;
  logic     gpr_a_vq_r, gpr_b_vq_r;
  logic     cnt_a_vq_r, cnt_b_vq_r, cnt_r_vq_r;

  // last update, for a read launched on the same edge
  logic     fwd_gpr_vld_r;
  gpr_idx_t fwd_gpr_idx_r;
  reg_t     fwd_gpr_data_r;
  logic     fwd_cnt_vld_r;
  gpr_idx_t fwd_cnt_idx_r;
  cnt_t     fwd_cnt_data_r;

  reg_t gpr_a, gpr_b;
  cnt_t cnt_a, cnt_b, cnt_r;

  // memory arrays
  always_ff @(posedge clk) begin
    if (wr.gpr_we) begin
      gpr_mem_r[wr.gpr_idx] <= wr.gpr_data;
    end
    if (wr.cnt_we) begin
      cnt_ab_mem_r[wr.cnt_idx] <= wr.cnt_data;
      cnt_rs_mem_r[wr.cnt_idx] <= wr.cnt_data;
    end
    if (rd_en) begin
      addr_q_r  <= rd_addr;
      gpr_a_q_r <= gpr_mem_r[rd_addr.a];
      gpr_b_q_r <= gpr_mem_r[rd_addr.b];
      cnt_a_q_r <= cnt_ab_mem_r[rd_addr.a];
      cnt_b_q_r <= cnt_ab_mem_r[rd_addr.b];
      cnt_r_q_r <= cnt_rs_mem_r[rd_addr.r];
    end
  end

  // valid bits, link flops and forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpr_vld_r      <= '0;
      cnt_vld_r      <= '0;
      link_r         <= '0;
      link_cnt_r     <= '0;
      gpr_a_vq_r     <= 1'b0;
      gpr_b_vq_r     <= 1'b0;
      cnt_a_vq_r     <= 1'b0;
      cnt_b_vq_r     <= 1'b0;
      cnt_r_vq_r     <= 1'b0;
      fwd_gpr_vld_r  <= 1'b0;
      fwd_gpr_idx_r  <= '0;
      fwd_gpr_data_r <= '0;
      fwd_cnt_vld_r  <= 1'b0;
      fwd_cnt_idx_r  <= '0;
      fwd_cnt_data_r <= '0;
    end else begin
      if (rd_en) begin
        gpr_a_vq_r <= gpr_vld_r[rd_addr.a];
        gpr_b_vq_r <= gpr_vld_r[rd_addr.b];
        cnt_a_vq_r <= cnt_vld_r[rd_addr.a];
        cnt_b_vq_r <= cnt_vld_r[rd_addr.b];
        cnt_r_vq_r <= cnt_vld_r[rd_addr.r];
      end
      if (wr.gpr_we) begin
        gpr_vld_r[wr.gpr_idx] <= 1'b1;
        fwd_gpr_vld_r         <= 1'b1;
        fwd_gpr_idx_r         <= wr.gpr_idx;
        fwd_gpr_data_r        <= wr.gpr_data;
      end
      if (wr.cnt_we) begin
        cnt_vld_r[wr.cnt_idx] <= 1'b1;
        fwd_cnt_vld_r         <= 1'b1;
        fwd_cnt_idx_r         <= wr.cnt_idx;
        fwd_cnt_data_r        <= wr.cnt_data;
      end
      if (wr.link_we) begin
        link_r <= wr.link_data;
      end
      if (wr.link_cnt_we) begin
        link_cnt_r <= wr.link_cnt_data;
      end
    end
  end

  // resolve reads: forwarded update, then stored entry, then reset value
  always_comb begin
    gpr_a = (fwd_gpr_vld_r && fwd_gpr_idx_r == addr_q_r.a) ? fwd_gpr_data_r :
            (gpr_a_vq_r ? gpr_a_q_r : '0);
    gpr_b = (fwd_gpr_vld_r && fwd_gpr_idx_r == addr_q_r.b) ? fwd_gpr_data_r :
            (gpr_b_vq_r ? gpr_b_q_r : '0);
    cnt_a = (fwd_cnt_vld_r && fwd_cnt_idx_r == addr_q_r.a) ? fwd_cnt_data_r :
            (cnt_a_vq_r ? cnt_a_q_r : '0);
    cnt_b = (fwd_cnt_vld_r && fwd_cnt_idx_r == addr_q_r.b) ? fwd_cnt_data_r :
            (cnt_b_vq_r ? cnt_b_q_r : '0);
    cnt_r = (fwd_cnt_vld_r && fwd_cnt_idx_r == addr_q_r.r) ? fwd_cnt_data_r :
            (cnt_r_vq_r ? cnt_r_q_r : '0);

    rsp.val_a     = 32'(gpr_a);
    rsp.val_b     = 32'(gpr_b);
    rsp.link_val  = 32'(link_r);
    rsp.busy_a    = (cnt_a != '0);
    rsp.busy_b    = (cnt_b != '0);
    rsp.link_busy = (link_cnt_r != '0);
    rsp.cnt_r     = cnt_r;
    rsp.link_cnt  = link_cnt_r;
  end

endmodule

`default_nettype wire

// ===== hdl/decode_stage_with_scoreboard.sv =====
// decode_stage_with_scoreboard: top level of the decode stage.
// Depends on dss_pkg and dss_score.
//
// Usage
//   Input channel (in_valid/in_ready/in_data) carries decode and writeback
//   items. A decode item gives exactly one result on the output channel
//   (out_valid/out_ready/out_data); a writeback item gives no result and,
//   up to the link index, updates the register file and releases one reservation.
//   Result fields that an item does not write keep their last value.
//   The scoreboard read for an item is launched at the edge that accepts
//   it; the item then waits in the input register, and its result is
//   registered in the result register as the item leaves, raising out_valid.
//   Throughput: one item per cycle, sustained while out_ready stays high. The
//   scoreboard forwards the previous item's update into the following read.
//   While a decode item waits behind a held result, in_ready follows out_ready in the same cycle.
//   Reset (rst_n low, synchronous, one cycle) clears the held result, and
//   through valid bits the register file and pending counts, to zero.
//   When the receiver holds out_ready low, the result register keeps its
//   item; one more item waits in the input register and then in_ready drops.
//   A writeback item in the input register leaves even while results stall.
`timescale 1ns / 1ps
`default_nettype none

module decode_stage_with_scoreboard (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dss_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dss_pkg::out_item_t      out_data
);
  import dss_pkg::*;

  logic      s1_vld_r, s1_vld_nxt;
  in_item_t  s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic      in_acc, out_free, s1_go, s1_dec;
  rd_addr_t  rd_addr, s1_addr;
  sb_wr_t    wr_c, sb_wr;
  sb_rsp_t   sb_rsp;
  out_item_t res;
  logic      hz, ok, rsv, rsv_link;

  // handshake
  assign out_free  = !out_valid_r || out_ready;
  assign s1_dec    = (s1_data_r.op == OP_DECODE);
  assign s1_go     = s1_vld_r && (!s1_dec || out_free);
  assign in_ready  = !s1_vld_r || s1_go;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // scoreboard reads launch as the item is accepted
  assign rd_addr = src_addrs(in_data);
  assign s1_addr = src_addrs(s1_data_r);
  assign sb_wr   = s1_go ? wr_c : '0;

  dss_score u_score (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .wr      (sb_wr),
    .rsp     (sb_rsp)
  );

  // decode and writeback for the item in the input register
  always_comb begin
    res      = out_data_r;
    wr_c     = '0;
    hz       = 1'b0;
    ok       = 1'b0;
    rsv      = 1'b0;
    rsv_link = 1'b0;

    if (s1_data_r.op == OP_WRITEBACK) begin
      if (s1_data_r.wb_index < LINK_IDX) begin
        wr_c.gpr_we   = 1'b1;
        wr_c.gpr_idx  = s1_data_r.wb_index[IDX_W-1:0];
        wr_c.gpr_data = DATA_WIDTH'($unsigned(s1_data_r.wb_value));
        wr_c.cnt_we   = 1'b1;
        wr_c.cnt_idx  = s1_addr.r;
        wr_c.cnt_data = cnt_dec(sb_rsp.cnt_r);
      end else if (s1_data_r.wb_index == LINK_IDX) begin
        wr_c.link_we       = 1'b1;
        wr_c.link_data     = DATA_WIDTH'($unsigned(s1_data_r.wb_value));
        wr_c.link_cnt_we   = 1'b1;
        wr_c.link_cnt_data = cnt_dec(sb_rsp.link_cnt);
      end
    end else if (s1_data_r.stall_in) begin
      res.stage_status = 1'b1;
    end else begin
      unique case (s1_data_r.opcode)
        OPC_CSW: begin
          res.out_opcode = OPC_CSW;
          res.out_first  = '0;
          res.out_second = '0;
          res.out_third  = '0;
        end
        OPC_ADDI, OPC_LW: begin
          hz = sb_rsp.busy_a;
          if (!hz) begin
            ok                = 1'b1;
            rsv               = 1'b1;
            res.operand_a     = sb_rsp.val_a;
            res.immediate_out = s1_data_r.field_third;
          end
        end
        OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV: begin
          hz = sb_rsp.busy_a || sb_rsp.busy_b;
          if (!hz) begin
            ok            = 1'b1;
            rsv           = 1'b1;
            res.operand_a = sb_rsp.val_a;
            res.operand_b = sb_rsp.val_b;
          end
        end
        OPC_SW: begin
          hz = sb_rsp.busy_a || sb_rsp.busy_b;
          if (!hz) begin
            ok                = 1'b1;
            res.operand_a     = sb_rsp.val_a;
            res.operand_b     = sb_rsp.val_b;
            res.immediate_out = s1_data_r.field_third;
          end
        end
        OPC_BEQ, OPC_BNE: begin
          hz = sb_rsp.busy_a || sb_rsp.busy_b;
          if (!hz) begin
            ok                = 1'b1;
            res.operand_a     = sb_rsp.val_a;
            res.operand_b     = sb_rsp.val_b;
            res.branch_target = s1_data_r.pc_value +
                                {s1_data_r.field_third[29:0], 2'b00};
          end
        end
        OPC_LR: begin
          hz = sb_rsp.busy_a;
          if (!hz) begin
            ok            = 1'b1;
            rsv           = 1'b1;
            rsv_link      = 1'b1;
            res.operand_a = sb_rsp.val_a;
          end
        end
        OPC_SC: begin
          hz = sb_rsp.busy_a || sb_rsp.busy_b || sb_rsp.link_busy;
          if (!hz) begin
            ok                = 1'b1;
            rsv               = 1'b1;
            res.operand_a     = sb_rsp.val_a;
            res.operand_b     = sb_rsp.val_b;
            res.immediate_out = s1_data_r.field_third;
            res.link_value    = sb_rsp.link_val;
          end
        end
        OPC_JAL: begin
          hz = sb_rsp.busy_a;
          if (!hz) begin
            ok                = 1'b1;
            rsv               = 1'b1;
            res.operand_a     = s1_data_r.pc_value;
            res.branch_target = s1_data_r.pc_value + $unsigned(s1_data_r.field_third);
          end
        end
        OPC_JALR: begin
          hz = sb_rsp.busy_a;
          if (!hz) begin
            ok                = 1'b1;
            rsv               = 1'b1;
            res.operand_a     = s1_data_r.pc_value;
            res.branch_target = sb_rsp.val_a + $unsigned(s1_data_r.field_third);
          end
        end
        OPC_NOP: begin
          res.out_opcode = s1_data_r.opcode;
          res.out_first  = s1_data_r.field_first;
          res.out_second = s1_data_r.field_second;
          res.out_third  = s1_data_r.field_third;
        end
        default: begin
          // unknown opcode: held result goes out again
        end
      endcase

      // hazard bubble
      if (hz) begin
        res.out_opcode   = OPC_BUBBLE;
        res.out_first    = '0;
        res.out_second   = '0;
        res.out_third    = '0;
        res.stage_status = 1'b1;
      end

      // instruction passes on
      if (ok) begin
        res.out_opcode   = s1_data_r.opcode;
        res.out_first    = s1_data_r.field_first;
        res.out_second   = s1_data_r.field_second;
        res.out_third    = s1_data_r.field_third;
        res.stage_status = 1'b0;
      end

      // destination reservations
      if (rsv) begin
        wr_c.cnt_we   = 1'b1;
        wr_c.cnt_idx  = s1_addr.r;
        wr_c.cnt_data = cnt_inc(sb_rsp.cnt_r);
      end
      if (rsv_link) begin
        wr_c.link_cnt_we   = 1'b1;
        wr_c.link_cnt_data = cnt_inc(sb_rsp.link_cnt);
      end
    end
  end

  // next-state for input and result registers
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (s1_go && s1_dec) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and held result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dss_check.sv =====
// dss_check: port-level checks for the decode stage, bound to the top level.
// Depends on dss_pkg and decode_stage_with_scoreboard.
`timescale 1ns / 1ps
`default_nettype none

module dss_check (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire dss_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire dss_pkg::out_item_t out_data
);
  import dss_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // a fresh result follows an accepted decode item
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_data.op == OP_DECODE, 2))
    else $error("result item without a matching decode item");

  // a bubble always reports a stall with cleared fields
  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_opcode == OPC_BUBBLE |->
      out_data.stage_status && out_data.out_first == '0 &&
      out_data.out_second == '0 && out_data.out_third == '0)
    else $error("bubble with status clear or fields set");

  // a context switch carries cleared fields
  a_csw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_opcode == OPC_CSW |->
      out_data.out_first == '0 && out_data.out_second == '0 &&
      out_data.out_third == '0)
    else $error("context switch with fields set");

endmodule

bind decode_stage_with_scoreboard dss_check u_dss_check (.*);

`default_nettype wire

// ===== dv/decode_result_checker.sv =====
// decode_result_checker: watches both channels of the decode stage, predicts each
// result from its own copy of the register file and pending counts, and compares.
// Depends on dss_pkg for the item types, sizes and opcodes.
`timescale 1ns / 1ps

module decode_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  dss_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  dss_pkg::out_item_t out_data,
  output int                 mismatches,
  output int                 awaiting,
  output int                 results_checked,
  output int                 bubbles_seen
);
  import dss_pkg::*;

  localparam int LINK_REG = NUM_REGS - 1;

  // shadow copy of the stage state
  logic [31:0]            gpr_model  [NUM_REGS];
  logic [COUNT_WIDTH-1:0] pend_model [NUM_REGS];
  out_item_t              held;
  out_item_t              predicted_decodes [$];
  out_item_t              want;

  initial begin
    mismatches      = 0;
    awaiting        = 0;
    results_checked = 0;
    bubbles_seen    = 0;
    held            = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      gpr_model[i]  = '0;
      pend_model[i] = '0;
    end
  end

  function automatic bit is_pending(int idx);
    return pend_model[idx] != '0;
  endfunction

  // raise a pending count, sticking at the top
  function automatic void add_pending(int idx);
    if (pend_model[idx] != CNT_MAX) begin
      pend_model[idx] = pend_model[idx] + cnt_t'(1);
    end
  endfunction

  // nop-style result: passed-on fields cleared, operands kept
  function automatic void hold_nop(logic [9:0] kind, bit stalled);
    held.out_opcode = kind;
    held.out_first  = '0;
    held.out_second = '0;
    held.out_third  = '0;
    if (stalled) begin
      held.stage_status = 1'b1;
    end
  endfunction

  // writeback: store the value and release one reservation
  function automatic void apply_writeback(in_item_t it);
    int idx;
    idx = int'(it.wb_index);
    if (idx < NUM_REGS) begin
      gpr_model[idx] = it.wb_value;
      if (pend_model[idx] != '0) begin
        pend_model[idx] = pend_model[idx] - cnt_t'(1);
      end
    end
  endfunction

  // work out the result of one decode item
  function automatic void predict_decode(in_item_t it);
    logic [31:0] third;
    logic [31:0] pc;
    int          f1;
    int          f2;
    int          f3i;
    bit          done;
    third = it.field_third;
    pc    = it.pc_value;
    f1    = int'(it.field_first);
    f2    = int'(it.field_second);
    f3i   = int'(it.field_third[4:0]);
    done  = 1'b0;
    if (it.stall_in) begin
      held.stage_status = 1'b1;
    end else begin
      case (it.opcode)
        OPC_CSW: hold_nop(OPC_CSW, 1'b0);
        OPC_ADDI, OPC_LW: begin
          if (is_pending(f2)) begin
            hold_nop(OPC_BUBBLE, 1'b1);
          end else begin
            add_pending(f1);
            held.operand_a     = gpr_model[f2];
            held.immediate_out = third;
            done = 1'b1;
          end
        end
        OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV: begin
          if (is_pending(f2) || is_pending(f3i)) begin
            hold_nop(OPC_BUBBLE, 1'b1);
          end else begin
            add_pending(f1);
            held.operand_a = gpr_model[f2];
            held.operand_b = gpr_model[f3i];
            done = 1'b1;
          end
        end
        OPC_SW: begin
          if (is_pending(f1) || is_pending(f2)) begin
            hold_nop(OPC_BUBBLE, 1'b1);
          end else begin
            held.operand_a     = gpr_model[f1];
            held.operand_b     = gpr_model[f2];
            held.immediate_out = third;
            done = 1'b1;
          end
        end
        OPC_BEQ, OPC_BNE: begin
          if (is_pending(f1) || is_pending(f2)) begin
            hold_nop(OPC_BUBBLE, 1'b1);
          end else begin
            held.operand_a     = gpr_model[f1];
            held.operand_b     = gpr_model[f2];
            held.branch_target = pc + (third << 2);
            done = 1'b1;
          end
        end
        OPC_LR: begin
          if (is_pending(f2)) begin
            hold_nop(OPC_BUBBLE, 1'b1);
          end else begin
            add_pending(f1);
            add_pending(LINK_REG);
            held.operand_a = gpr_model[f2];
            done = 1'b1;
          end
        end
        OPC_SC: begin
          if (is_pending(f1) || is_pending(f2) || is_pending(LINK_REG)) begin
            hold_nop(OPC_BUBBLE, 1'b1);
          end else begin
            add_pending(f2);
            held.operand_a     = gpr_model[f1];
            held.operand_b     = gpr_model[f2];
            held.immediate_out = third;
            held.link_value    = gpr_model[LINK_REG];
            done = 1'b1;
          end
        end
        OPC_JAL: begin
          if (is_pending(f2)) begin
            hold_nop(OPC_BUBBLE, 1'b1);
          end else begin
            add_pending(f1);
            held.operand_a     = pc;
            held.branch_target = pc + third;
            done = 1'b1;
          end
        end
        OPC_JALR: begin
          if (is_pending(f2)) begin
            hold_nop(OPC_BUBBLE, 1'b1);
          end else begin
            add_pending(f1);
            held.operand_a     = pc;
            held.branch_target = gpr_model[f2] + third;
            done = 1'b1;
          end
        end
        OPC_NOP: begin
          held.out_opcode = it.opcode;
          held.out_first  = it.field_first;
          held.out_second = it.field_second;
          held.out_third  = it.field_third;
        end
        default: ;
      endcase
      if (done) begin
        held.out_opcode   = it.opcode;
        held.out_first    = it.field_first;
        held.out_second   = it.field_second;
        held.out_third    = it.field_third;
        held.stage_status = 1'b0;
      end
    end
    predicted_decodes.push_back(held);
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // results retire before the item accepted at the same edge is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (predicted_decodes.size() == 0) begin
          $error("result item with nothing expected: out_opcode 0x%03h", out_data.out_opcode);
          mismatches++;
        end else begin
          want = predicted_decodes.pop_front();
          results_checked++;
          if (want.out_opcode == OPC_BUBBLE && want.stage_status) begin
            bubbles_seen++;
          end
          compare_field("out_opcode", 32'(want.out_opcode), 32'(out_data.out_opcode));
          compare_field("out_first", 32'(want.out_first), 32'(out_data.out_first));
          compare_field("out_second", 32'(want.out_second), 32'(out_data.out_second));
          compare_field("out_third", want.out_third, out_data.out_third);
          compare_field("stage_status", 32'(want.stage_status), 32'(out_data.stage_status));
          compare_field("operand_a", want.operand_a, out_data.operand_a);
          compare_field("operand_b", want.operand_b, out_data.operand_b);
          compare_field("immediate_out", want.immediate_out, out_data.immediate_out);
          compare_field("branch_target", want.branch_target, out_data.branch_target);
          compare_field("link_value", want.link_value, out_data.link_value);
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.op == OP_WRITEBACK) begin
          apply_writeback(in_data);
        end else begin
          predict_decode(in_data);
        end
      end
    end
    awaiting <= predicted_decodes.size();
  end

endmodule

// ===== dv/tb_decode_stage_with_scoreboard.sv =====
// tb_decode_stage_with_scoreboard: drives decode and writeback items into the
// decode stage with random gaps and back-pressure; decode_result_checker judges.
// Depends on dss_pkg, decode_stage_with_scoreboard and decode_result_checker.
`timescale 1ns / 1ps

module tb_decode_stage_with_scoreboard;
  import dss_pkg::*;

  localparam int ITEM_GOAL      = 750;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  // an opcode that the stage does not know
  localparam logic [9:0] OPC_UNKNOWN = 10'h3ff;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int mismatches;
  int awaiting;
  int results_checked;
  int bubbles_seen;

  bit         steady;
  int         items_counted;
  int         writebacks_sent;
  int         quiet_cycles;
  logic [5:0] owed_writebacks [$];

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  decode_stage_with_scoreboard DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  decode_result_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatches      (mismatches),
    .awaiting        (awaiting),
    .results_checked (results_checked),
    .bubbles_seen    (bubbles_seen)
  );

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 27);
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // mostly a handful of registers so that hazards come often
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 3) == 0) begin
      return 5'($urandom_range(0, 31));
    end
    return 5'($urandom_range(1, 7));
  endfunction

  function automatic logic [9:0] known_opcode(int k);
    case (k)
      0: return OPC_CSW;
      1: return OPC_LW;
      2: return OPC_ADDI;
      3: return OPC_SW;
      4: return OPC_LR;
      5: return OPC_SC;
      6: return OPC_DIV;
      7: return OPC_ADD;
      8: return OPC_MUL;
      9: return OPC_SUB;
      10: return OPC_BEQ;
      11: return OPC_BNE;
      12: return OPC_JALR;
      13: return OPC_JAL;
      default: return OPC_NOP;
    endcase
  endfunction

  function automatic in_item_t random_fields();
    in_item_t it;
    it.op           = 1'($urandom);
    it.opcode       = 10'($urandom);
    it.field_first  = 5'($urandom);
    it.field_second = 5'($urandom);
    it.field_third  = pick_word();
    it.stall_in     = 1'($urandom);
    it.pc_value     = pick_word();
    it.wb_index     = 6'($urandom_range(0, 63));
    it.wb_value     = pick_word();
    return it;
  endfunction

  function automatic in_item_t decode_of(logic [9:0] opc, logic [4:0] f1, logic [4:0] f2,
                                         logic [31:0] f3, logic [31:0] pc);
    in_item_t it;
    it              = random_fields();
    it.op           = OP_DECODE;
    it.stall_in     = 1'b0;
    it.opcode       = opc;
    it.field_first  = f1;
    it.field_second = f2;
    it.field_third  = f3;
    it.pc_value     = pc;
    return it;
  endfunction

  function automatic in_item_t writeback_to(logic [5:0] idx, logic [31:0] val);
    in_item_t it;
    it          = random_fields();
    it.op       = OP_WRITEBACK;
    it.wb_index = idx;
    it.wb_value = val;
    return it;
  endfunction

  function automatic in_item_t random_decode();
    in_item_t it;
    it          = decode_of(known_opcode($urandom_range(0, 14)), pick_reg(), pick_reg(),
                            pick_word(), pick_word());
    it.stall_in = ($urandom_range(0, 99) < 4);
    if ($urandom_range(0, 1)) begin
      it.field_third[4:0] = pick_reg();
    end
    return it;
  endfunction

  // remember destinations so that writebacks can release them later
  function automatic void note_reservations(in_item_t it);
    if (it.op == OP_DECODE && !it.stall_in) begin
      case (it.opcode)
        OPC_ADDI, OPC_LW, OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV, OPC_JAL, OPC_JALR:
          owed_writebacks.push_back(6'(it.field_first));
        OPC_LR: begin
          owed_writebacks.push_back(6'(it.field_first));
          owed_writebacks.push_back(LINK_IDX);
        end
        OPC_SC: owed_writebacks.push_back(6'(it.field_second));
        default: ;
      endcase
    end
  endfunction

  // present one item from a falling edge and hold it until accepted
  task automatic send_item(input in_item_t it);
    while (!steady && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    note_reservations(it);
    if (it.op == OP_WRITEBACK) begin
      writebacks_sent++;
    end
    if (!(it.op == OP_WRITEBACK && it.wb_index >= NUM_REGS)) begin
      items_counted++;
    end
  endtask

  initial begin
    in_item_t   item;
    logic [5:0] idx;
    logic [4:0] dest;
    int         roll;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_ready       = 1'b0;
    steady          = 1'b0;
    items_counted   = 0;
    writebacks_sent = 0;
    quiet_cycles    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extreme values, every opcode, hazards, wrap, unknown and stalled items
    send_item(writeback_to(6'd1, 32'h8000_0000));
    send_item(writeback_to(6'd2, 32'h7fff_ffff));
    send_item(writeback_to(LINK_IDX, 32'h1234_5678));
    send_item(writeback_to(6'd63, 32'hffff_ffff));
    send_item(decode_of(OPC_ADDI, 5'd3, 5'd1, 32'h7fff_ffff, 32'hffff_ffff));
    send_item(decode_of(OPC_ADD, 5'd4, 5'd3, 32'd2, 32'h0));
    send_item(writeback_to(6'd3, 32'd5));
    send_item(decode_of(OPC_ADD, 5'd4, 5'd2, 32'hffff_ffe1, 32'h0));
    send_item(decode_of(OPC_SUB, 5'd5, 5'd1, 32'd2, 32'h4));
    send_item(decode_of(OPC_MUL, 5'd31, 5'd1, 32'd2, 32'h8));
    send_item(decode_of(OPC_DIV, 5'd0, 5'd2, 32'd1, 32'hc));
    send_item(decode_of(OPC_LW, 5'd6, 5'd1, 32'h8000_0000, 32'h10));
    send_item(decode_of(OPC_SW, 5'd1, 5'd2, 32'h8000_0000, 32'h14));
    send_item(decode_of(OPC_BEQ, 5'd1, 5'd2, 32'd1, 32'hffff_fffc));
    send_item(decode_of(OPC_BNE, 5'd1, 5'd2, 32'h8000_0000, 32'h1000));
    send_item(decode_of(OPC_LR, 5'd7, 5'd1, 32'h0, 32'h1004));
    send_item(decode_of(OPC_SC, 5'd1, 5'd2, 32'h40, 32'h1008));
    send_item(writeback_to(LINK_IDX, 32'hffff_ffff));
    send_item(decode_of(OPC_SC, 5'd1, 5'd2, 32'h40, 32'h100c));
    send_item(decode_of(OPC_JAL, 5'd8, 5'd1, 32'h7fff_ffff, 32'hffff_ffff));
    send_item(decode_of(OPC_JALR, 5'd9, 5'd1, 32'hffff_ffff, 32'h2000));
    send_item(decode_of(OPC_CSW, 5'd1, 5'd1, 32'h1, 32'h2004));
    send_item(decode_of(OPC_NOP, 5'd31, 5'd31, 32'hffff_ffff, 32'h2008));
    send_item(decode_of(OPC_UNKNOWN, 5'd31, 5'd31, 32'hffff_ffff, 32'h200c));
    item          = decode_of(OPC_ADDI, 5'd10, 5'd1, 32'h7, 32'h2010);
    item.stall_in = 1'b1;
    send_item(item);

    // random: decode streams kept alive by writebacks, bursts that saturate counts, noise
    while (items_counted < ITEM_GOAL) begin
      steady = (items_counted >= 300) && (items_counted < 420);
      roll   = $urandom_range(0, 99);
      if (roll < 45) begin
        send_item(random_decode());
      end else if (roll < 82) begin
        if (owed_writebacks.size() != 0) begin
          idx = owed_writebacks.pop_front();
        end else begin
          idx = 6'($urandom_range(0, 32));
        end
        send_item(writeback_to(idx, pick_word()));
      end else if (roll < 86) begin
        dest = 5'($urandom_range(1, 31));
        repeat ($urandom_range(7, 9)) begin
          send_item(decode_of(OPC_ADDI, dest, 5'd0, pick_word(), pick_word()));
        end
      end else begin
        send_item(random_fields());
      end
    end
    in_valid <= 1'b0;
    steady   = 1'b0;

    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d items sent (%0d writebacks), %0d decode results checked",
             items_counted, writebacks_sent, results_checked);
    $display("summary: %0d hazard bubbles among them, %0d mismatches",
             bubbles_seen, mismatches);
    if (mismatches == 0 && awaiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== decode_stage_with_scoreboard.f =====
hdl/dss_pkg.sv
hdl/dss_score.sv
hdl/decode_stage_with_scoreboard.sv
hdl/dss_check.sv
dv/decode_result_checker.sv
dv/tb_decode_stage_with_scoreboard.sv
